// File: sv/kgsr_pkg.sv
// Shared types and constants for the k-group stream reverser.
`timescale 1ns / 1ps

package kgsr_pkg;

  // Width of the group size register
  localparam int unsigned GS_W = 5;

  // Reset value of the group size register
  localparam logic [GS_W-1:0] GS_RESET = GS_W'(2);

  // Per-cell shift command
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_DOWN,
    CELL_UP
  } cell_op_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_FILL,
    ST_REV,
    ST_FWD
  } state_t;

endpackage

// File: sv/k_group_stream_reverser.sv
// Top level: collects values in a chain of cells and sends each group back out.
// The transfer that closes a group enters a drain state, which loads the first result into out_*.
// Each group is taken in while in_ready is high, then drained while in_ready is low; the drain
//   rate is one result per cycle while the receiver keeps out_ready high, set by the single output register.
// Reset (rst_n, synchronous, active low) clears the fill count, state and output valid, and
//   sets the group size to 2; cell contents are undefined until written.
`timescale 1ns / 1ps

module k_group_stream_reverser
  import kgsr_pkg::*;
#(
  parameter int unsigned MAX_GROUP   = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [GS_W-1:0]               cfg_group_size,
  // input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  input  logic                          in_end_of_sequence,
  // result items
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] out_value_out,
  output logic                          out_last_out
);

  localparam int unsigned CNT_W = $clog2(MAX_GROUP + 1);
  localparam int unsigned IDX_W = $clog2(MAX_GROUP);
  localparam int unsigned CMP_W = (CNT_W > GS_W) ? CNT_W : GS_W;

  // Registers
  logic [GS_W-1:0]        gs_r;
  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [CNT_W-1:0]       rem_r, rem_nxt;
  logic                   last_r, last_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [VALUE_WIDTH-1:0] out_value_r, out_value_nxt;
  logic                   out_last_r, out_last_nxt;

  // Cell chain
  logic [VALUE_WIDTH-1:0] cell_q [MAX_GROUP];
  cell_op_t               cell_op;

  logic                   in_xfer;
  logic                   slot_free;
  logic [CMP_W-1:0]       gs_ext, k_eff, c_ext;
  logic [CNT_W-1:0]       rem_m1;
  logic [IDX_W-1:0]       tail_idx;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gs_r <= GS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      gs_r <= cfg_group_size;
    end
  end

  // Effective group size: zero acts as one, large values saturate
  always_comb begin
    gs_ext = CMP_W'(gs_r);
    if (gs_ext == '0) begin
      k_eff = CMP_W'(1);
    end else if (gs_ext > CMP_W'(MAX_GROUP)) begin
      k_eff = CMP_W'(MAX_GROUP);
    end else begin
      k_eff = gs_ext;
    end
  end

  assign c_ext    = CMP_W'(cnt_r) + CMP_W'(1);
  assign rem_m1   = rem_r - CNT_W'(1);
  assign tail_idx = rem_m1[IDX_W-1:0];

  assign in_ready  = (state_r == ST_FILL);
  assign in_xfer   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // Build the chain: shift down on fill, up on reversed drain
  for (genvar i = 0; i < MAX_GROUP; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] down_src, up_src;
    if (i == 0) begin : g_head
      assign down_src = in_value;
    end else begin : g_body
      assign down_src = cell_q[i-1];
    end
    if (i == MAX_GROUP - 1) begin : g_tail
      assign up_src = cell_q[i];
    end else begin : g_mid
      assign up_src = cell_q[i+1];
    end
    kgsr_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk    (clk),
      .op     (cell_op),
      .down_in(down_src),
      .up_in  (up_src),
      .q      (cell_q[i])
    );
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      cnt_r       <= '0;
      rem_r       <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Next state, cell commands and output loading
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    last_nxt      = last_r;
    cell_op       = CELL_HOLD;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_FILL: begin
        if (in_xfer) begin
          cell_op  = CELL_DOWN;
          last_nxt = in_end_of_sequence;
          if (c_ext >= k_eff) begin
            state_nxt = ST_REV;
            rem_nxt   = CNT_W'(c_ext);
            cnt_nxt   = '0;
          end else if (in_end_of_sequence) begin
            state_nxt = ST_FWD;
            rem_nxt   = CNT_W'(c_ext);
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = CNT_W'(c_ext);
          end
        end
      end
      ST_REV: begin
        // Newest sits in cell 0; advance the chain toward it
        if (slot_free) begin
          cell_op       = CELL_UP;
          out_valid_nxt = 1'b1;
          out_value_nxt = cell_q[0];
          out_last_nxt  = last_r && (rem_r == CNT_W'(1));
          rem_nxt       = rem_m1;
          if (rem_r == CNT_W'(1)) begin
            state_nxt = ST_FILL;
          end
        end
      end
      ST_FWD: begin
        // Oldest sits deepest; walk back toward cell 0
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = cell_q[tail_idx];
          out_last_nxt  = last_r && (rem_r == CNT_W'(1));
          rem_nxt       = rem_m1;
          if (rem_r == CNT_W'(1)) begin
            state_nxt = ST_FILL;
          end
        end
      end
      default: begin
        state_nxt = ST_FILL;
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_value_out = out_value_r;
  assign out_last_out  = out_last_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CNT_W'(MAX_GROUP))
    else $error("fill count reached group capacity");

  a_drain_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_FILL) |-> (rem_r != '0))
    else $error("draining with nothing left");

  a_fill_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL && out_valid_r && out_ready) |=> !out_valid_r)
    else $error("result produced while filling");

  a_drain_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (c_ext >= k_eff)) |=> !in_ready)
    else $error("input taken during group drain");

endmodule

// File: sv/kgsr_cell.sv
// One storage cell of the bidirectional shift chain.
`timescale 1ns / 1ps

module kgsr_cell
  import kgsr_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  cell_op_t               op,
  input  logic [VALUE_WIDTH-1:0] down_in,
  input  logic [VALUE_WIDTH-1:0] up_in,
  output logic [VALUE_WIDTH-1:0] q
);

  logic [VALUE_WIDTH-1:0] data_r;

  // Take the neighbor's value or hold
  always_ff @(posedge clk) begin
    case (op)
      CELL_DOWN: data_r <= down_in;
      CELL_UP:   data_r <= up_in;
      default:   data_r <= data_r;
    endcase
  end

  assign q = data_r;

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the k-group stream reverser.
`timescale 1ns / 1ps

module testbench;
  import kgsr_pkg::*;

  localparam int unsigned MAX_GROUP   = 16;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned SETTLE      = 6;       // settle time, in cycles, after the bench goes idle
  localparam int unsigned HOLDOFF     = 300;     // long receiver stall, in cycles
  localparam int unsigned ITEMS_PER_PHASE = 38;
  localparam int unsigned NUM_PHASES  = 10;
  localparam int unsigned CYCLE_LIMIT = 300000;

  typedef logic signed [VALUE_WIDTH-1:0] word_t;

  typedef struct {
    word_t value;
    logic  eos;
  } seq_item_t;

  typedef struct {
    word_t value;
    logic  last;
  } rev_result_t;

  // DUT signals; the inputs are known from time zero
  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [GS_W-1:0] cfg_group_size = '0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  word_t           in_value = '0;
  logic            in_end_of_sequence = 1'b0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  word_t           out_value_out;
  logic            out_last_out;

  // Reordering predictor state
  word_t           held_values [MAX_GROUP];
  int unsigned     held_count = 0;
  logic [GS_W-1:0] size_reg = GS_RESET;

  // Stimulus and expectation stores
  seq_item_t   values_to_send [$];
  rev_result_t reordered_q [$];
  seq_item_t   next_item;

  // Bookkeeping
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned items_in = 0;
  int unsigned results_out = 0;
  int unsigned cfg_writes = 0;
  bit          in_busy = 1'b0;
  int unsigned in_gap = 0;
  int unsigned rx_gap = 0;
  bit          in_idle_on = 1'b1;
  bit          out_idle_on = 1'b1;
  bit          holdoff_req = 1'b0;
  bit          rx_hold = 1'b0;

  k_group_stream_reverser #(
    .MAX_GROUP   (MAX_GROUP),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_group_size     (cfg_group_size),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_value           (in_value),
    .in_end_of_sequence (in_end_of_sequence),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_value_out      (out_value_out),
    .out_last_out       (out_last_out)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Store one value and queue whatever results it closes
  function automatic void predict_reorder(input word_t v, input logic eos);
    int unsigned k;
    int unsigned c;
    int unsigned i;
    rev_result_t r;
    k = 32'(size_reg);
    if (k == 0) k = 1;
    if (k > MAX_GROUP) k = MAX_GROUP;
    if (held_count >= MAX_GROUP) held_count = 0;
    held_values[held_count] = v;
    c = held_count + 1;
    if (c >= k) begin
      // full group: newest first
      for (i = 0; i < c; i++) begin
        r.value = held_values[c - 1 - i];
        r.last  = eos && (i + 1 == c);
        reordered_q.push_back(r);
      end
      held_count = 0;
    end else if (eos) begin
      // partial group closing the sequence: original order
      for (i = 0; i < c; i++) begin
        r.value = held_values[i];
        r.last  = (i + 1 == c);
        reordered_q.push_back(r);
      end
      held_count = 0;
    end else begin
      held_count = c;
    end
  endfunction

  function automatic void report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic word_t pick_value();
    int unsigned sel;
    sel = $urandom_range(11);
    if (sel == 0) return {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    if (sel == 1) return {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    if (sel == 2) return '1;
    if (sel == 3) return '0;
    return word_t'($urandom());
  endfunction

  // Monitor: track transfers, predict on input, check on output, watch the clock budget
  always @(posedge clk) begin
    rev_result_t exp_r;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        size_reg = cfg_group_size;
        cfg_writes++;
      end
      if (out_valid && out_ready) begin
        results_out++;
        if (reordered_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result: value %h last %b",
                                    out_value_out, out_last_out));
        end else begin
          exp_r = reordered_q.pop_front();
          if (out_value_out !== exp_r.value || out_last_out !== exp_r.last)
            report_mismatch($sformatf(
              "result %0d: value exp %h got %h, last exp %b got %b",
              results_out, exp_r.value, out_value_out, exp_r.last, out_last_out));
        end
      end
      if (in_valid && in_ready) begin
        predict_reorder(in_value, in_end_of_sequence);
        items_in++;
        in_busy = 1'b0;
      end
    end
  end

  // Input driver: hold until transfer, then idle for the chosen gap
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_busy) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (values_to_send.size() > 0) begin
        next_item = values_to_send.pop_front();
        in_valid           <= 1'b1;
        in_value           <= next_item.value;
        in_end_of_sequence <= next_item.eos;
        in_busy = 1'b1;
        in_gap  = in_idle_on ? pick_gap() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, forced low during a hold-off
  always @(negedge clk) begin
    if (!rst_n || rx_hold) begin
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      out_ready <= 1'b0;
      rx_gap--;
    end else begin
      out_ready <= 1'b1;
      rx_gap = out_idle_on ? pick_gap() : 0;
    end
  end

  // Long receiver hold-off on request
  always begin : rx_holdoff
    @(posedge clk);
    if (holdoff_req) begin
      rx_hold = 1'b1;
      repeat (HOLDOFF) @(posedge clk);
      rx_hold = 1'b0;
      holdoff_req = 1'b0;
    end
  end

  task automatic send(input word_t v, input logic eos);
    seq_item_t it;
    it.value = v;
    it.eos   = eos;
    values_to_send.push_back(it);
  endtask

  // Wait until all items are taken and every expected result has arrived
  task automatic wait_idle();
    while (values_to_send.size() != 0 || in_busy || reordered_q.size() != 0 || holdoff_req)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_group_size(input logic [GS_W-1:0] sz);
    int unsigned n0;
    n0 = cfg_writes;
    @(negedge clk);
    cfg_group_size <= sz;
    cfg_valid      <= 1'b1;
    do @(negedge clk); while (cfg_writes == n0);
    cfg_valid <= 1'b0;
  endtask

  // Mostly whole sequences closed by an end flag, some loose single items
  task automatic queue_random_items(input int unsigned n, input logic [GS_W-1:0] sz);
    int unsigned k;
    int unsigned len;
    int unsigned j;
    bit          whole;
    logic        loose_eos;
    k = (sz == 0) ? 1 : ((sz > MAX_GROUP) ? MAX_GROUP : sz);
    while (n > 0) begin
      whole = ($urandom_range(99) < 80);
      len = whole ? $urandom_range(2 * k + 2, 1) : 1;
      if (len > n) len = n;
      loose_eos = 1'($urandom_range(1));
      for (j = 0; j < len; j++)
        send(pick_value(), whole ? (j == len - 1) : loose_eos);
      n -= len;
    end
  endtask

  initial begin
    logic [GS_W-1:0] phase_size [NUM_PHASES];
    int unsigned p;

    // Reset
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset size of two: extremes, full group with end flag, lone partial
    send(32'sh7FFFFFFF, 1'b0);
    send(32'sh80000000, 1'b0);
    send(32'shFFFFFFFF, 1'b0);
    send(32'sh00000000, 1'b1);
    send(32'sh00000001, 1'b1);
    wait_idle();

    // Zero size acts as pass-through
    write_group_size(GS_W'(0));
    send(32'shA5A5A5A5, 1'b0);
    send(32'sh5A5A5A5A, 1'b1);
    wait_idle();

    // Oversized size saturates; a short sequence leaves a partial group
    write_group_size(GS_W'(31));
    send(32'sh12345678, 1'b0);
    send(32'shFEDCBA98, 1'b0);
    send(32'sh0F0F0F0F, 1'b1);
    wait_idle();

    // Lower the size while values are held: next item flushes all, reversed
    write_group_size(GS_W'(8));
    send(32'sh00000011, 1'b0);
    send(32'sh00000022, 1'b0);
    send(32'sh00000033, 1'b0);
    wait_idle();
    write_group_size(GS_W'(2));
    send(32'sh00000044, 1'b0);
    wait_idle();

    // Size one passes values straight through
    write_group_size(GS_W'(1));
    send(32'sh55555555, 1'b1);
    send(32'shAAAAAAAA, 1'b0);
    wait_idle();

    // Random phases over several settings, extremes included
    phase_size = '{GS_W'(16), GS_W'(31), GS_W'(1), GS_W'(0), GS_W'(3),
                   GS_W'(17), GS_W'(2), GS_W'(4), GS_W'(0), GS_W'(0)};
    phase_size[8] = GS_W'($urandom_range(31));
    phase_size[9] = GS_W'($urandom_range(31));
    for (p = 0; p < NUM_PHASES; p++) begin
      in_idle_on  = (p % 3 != 1);
      out_idle_on = (p % 3 != 2);
      if (p == 2) begin
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
      end
      write_group_size(phase_size[p]);
      queue_random_items(ITEMS_PER_PHASE, phase_size[p]);
      // Back up the block: stall the receiver while the sender keeps going
      if (p == 7) begin
        in_idle_on  = 1'b0;
        holdoff_req = 1'b1;
      end
      wait_idle();
    end

    // Drain and look for leftovers or stray results
    wait_idle();
    if (reordered_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", reordered_q.size()));

    $display("Covered %0d input transfers, %0d result transfers, %0d group size writes.",
             items_in, results_out, cfg_writes);
    $display("Zero, oversized and mid-group size changes exercised; %0d mismatches.",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
